### rtl/core/hnlp_pkg.sv
// Shared types, constants and helpers for the HDL number literal parser.
// No dependencies; every other file of the block imports this package.
package hnlp_pkg;

   // Sizes fixed by the interface
   localparam int VALUE_W           = 64;
   localparam int WIDTH_W           = 7;
   localparam int CHAR_W            = 8;
   localparam int SIZE_W            = 17;
   localparam int COUNT_W           = 16;
   localparam int QUEUE_DEPTH       = 2;

   // Defaults for the top-level parameters
   localparam int MAX_WIDTH_DEF     = 64;
   localparam int UNSIZED_WIDTH_DEF = 32;

   // Saturation points of the size and digit counters
   localparam logic [SIZE_W-1:0]  SIZE_SAT  = '1;
   localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

   // Radix codes
   localparam logic [2:0] RK_DEC = 3'd0;
   localparam logic [2:0] RK_BIN = 3'd1;
   localparam logic [2:0] RK_OCT = 3'd2;
   localparam logic [2:0] RK_HEX = 3'd3;
   localparam logic [2:0] RK_STR = 3'd4;

   // Characters with a role of their own
   localparam logic [CHAR_W-1:0] CH_TICK  = 8'h27;
   localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
   localparam logic [CHAR_W-1:0] CH_US    = 8'h5F;

   // Input item
   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last_character;
   } hnlp_req_type;

   // Result item
   typedef struct packed {
      logic [VALUE_W-1:0] value_bits;
      logic [VALUE_W-1:0] unknown_bits;
      logic [WIDTH_W-1:0] width;
      logic               is_signed;
      logic               bad_character;
      logic               leading_underscore;
      logic               excess_digits;
      logic               width_too_large;
   } hnlp_rsp_type;

   // Classified character, front to back
   typedef struct packed {
      logic [CHAR_W-1:0] chr;
      logic              last;
      logic              is_dig;
      logic              is_hex;
      logic [3:0]        dval;
      logic              is_x;
      logic              is_z;
      logic              is_s;
      logic              is_us;
      logic              is_tick;
      logic              is_quote;
      logic              base_hit;
      logic [2:0]        base_rk;
   } hnlp_token_type;

   // Parser state at the end of a literal, back to result stage
   typedef struct packed {
      logic [2:0]         radix;
      logic               held_valid;
      logic               held_quote;
      logic [COUNT_W-1:0] count;
      logic [SIZE_W-1:0]  size;
      logic               size_given;
      logic               open_phase;
      logic               signed_flag;
      logic               bad;
      logic               leadus;
      logic               inv_seen;
      logic [COUNT_W-1:0] last_inv;
   } hnlp_snap_type;

   // floor(x / 3) for x below 256
   function automatic logic [6:0] div3(input logic [7:0] x);
      logic [15:0] p;
      p = {8'b0, x} * 16'd171;
      return p[15:9];
   endfunction

endpackage

### rtl/core/hnlp_front.sv
// Front of the literal parser: accepts characters, classifies them and
// queues the classified items for the back. Depends on hnlp_pkg.
module hnlp_front
   import hnlp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  hnlp_req_type   req_data,
   output logic           tok_valid,
   input  logic           tok_pop,
   output hnlp_token_type tok
);

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CHAR_W-1:0] LC_A = 8'h61;
   localparam logic [CHAR_W-1:0] LC_F = 8'h66;
   localparam logic [CHAR_W-1:0] LC_B = 8'h62;
   localparam logic [CHAR_W-1:0] LC_O = 8'h6F;
   localparam logic [CHAR_W-1:0] LC_H = 8'h68;
   localparam logic [CHAR_W-1:0] LC_D = 8'h64;
   localparam logic [CHAR_W-1:0] LC_S = 8'h73;
   localparam logic [CHAR_W-1:0] LC_X = 8'h78;
   localparam logic [CHAR_W-1:0] LC_Z = 8'h7A;
   localparam logic [CHAR_W-1:0] CH_0 = 8'h30;
   localparam logic [CHAR_W-1:0] CH_9 = 8'h39;

   hnlp_token_type cls;
   logic [CHAR_W-1:0] lc;

   hnlp_token_type     q_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               push;

   // Classification; OR-ing 0x20 folds upper-case letters onto lower-case
   always_comb begin
      lc           = req_data.character | 8'h20;
      cls.chr      = req_data.character;
      cls.last     = req_data.last_character;
      cls.is_dig   = (req_data.character >= CH_0) && (req_data.character <= CH_9);
      cls.is_hex   = cls.is_dig || ((lc >= LC_A) && (lc <= LC_F));
      cls.dval     = cls.is_dig ? req_data.character[3:0] : lc[3:0] + 4'd9;
      cls.is_x     = (lc == LC_X);
      cls.is_z     = (lc == LC_Z);
      cls.is_s     = (lc == LC_S);
      cls.is_us    = (req_data.character == CH_US);
      cls.is_tick  = (req_data.character == CH_TICK);
      cls.is_quote = (req_data.character == CH_QUOTE);
      cls.base_hit = 1'b1;
      case (lc)
         LC_B:    cls.base_rk = RK_BIN;
         LC_O:    cls.base_rk = RK_OCT;
         LC_H:    cls.base_rk = RK_HEX;
         LC_D:    cls.base_rk = RK_DEC;
         default: begin
            cls.base_rk  = RK_DEC;
            cls.base_hit = 1'b0;
         end
      endcase
   end

   // Queue control
   assign req_ready = (fill_ff != FILL_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign tok_valid = (fill_ff != '0);
   assign tok       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push    ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = tok_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + FILL_W'(push) - FILL_W'(tok_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

### rtl/core/hnlp_back.sv
// Back of the literal parser (uses hnlp_pkg): a phase machine that folds
// at most one classified token per cycle into size, value planes and flags.
module hnlp_back
   import hnlp_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 tok_valid,
   input  hnlp_token_type       tok,
   output logic                 tok_pop,
   output logic                 snap_valid,
   input  logic                 snap_ready,
   output hnlp_snap_type        snap,
   output logic [MAX_WIDTH-1:0] snap_known,
   output logic [MAX_WIDTH-1:0] snap_unknown
);

   localparam logic [2:0] PH_START  = 3'd0;
   localparam logic [2:0] PH_LEAD   = 3'd1;
   localparam logic [2:0] PH_TICK   = 3'd2;
   localparam logic [2:0] PH_SIGN   = 3'd3;
   localparam logic [2:0] PH_FIRST  = 3'd4;
   localparam logic [2:0] PH_BODY   = 3'd5;
   localparam logic [2:0] PH_STRING = 3'd6;

   logic [2:0]           phase_ff, phase_in;
   logic [2:0]           radix_ff, radix_in;
   logic                 signed_ff, signed_in;
   logic [SIZE_W-1:0]    size_ff, size_in;
   logic [MAX_WIDTH-1:0] known_ff, known_in;
   logic [MAX_WIDTH-1:0] unknown_ff, unknown_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [COUNT_W-1:0]   last_inv_ff, last_inv_in;
   logic                 inv_seen_ff, inv_seen_in;
   logic                 bad_ff, bad_in;
   logic                 leadus_ff, leadus_in;
   logic                 nondig_ff, nondig_in;
   logic [CHAR_W-1:0]    held_ff, held_in;
   logic                 held_valid_ff, held_valid_in;
   logic                 size_given_ff, size_given_in;

   logic                 do_lead, lead_first, do_after, do_first, do_body, do_string;
   logic [MAX_WIDTH-1:0] known_x10;
   logic [20:0]          size_x10;
   logic [COUNT_W-1:0]   count_inc;
   logic [3:0]           dig_a, dig_b;
   logic                 dig_bad;

   // A final character waits until the result stage can take the snapshot
   assign tok_pop    = tok_valid && (!tok.last || snap_ready);
   assign snap_valid = tok_valid && tok.last;

   // Shared arithmetic
   always_comb begin
      known_x10 = (known_ff << 3) + (known_ff << 1) + MAX_WIDTH'(tok.dval);
      size_x10  = ({4'b0, size_ff} << 3) + ({4'b0, size_ff} << 1) + 21'(tok.dval);
      count_inc = (count_ff == COUNT_SAT) ? count_ff : count_ff + 1'b1;
   end

   // Next parser state for the character at the queue head
   always_comb begin
      phase_in      = phase_ff;
      radix_in      = radix_ff;
      signed_in     = signed_ff;
      size_in       = size_ff;
      known_in      = known_ff;
      unknown_in    = unknown_ff;
      count_in      = count_ff;
      last_inv_in   = last_inv_ff;
      inv_seen_in   = inv_seen_ff;
      bad_in        = bad_ff;
      leadus_in     = leadus_ff;
      nondig_in     = nondig_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      size_given_in = size_given_ff;
      do_lead       = 1'b0;
      lead_first    = 1'b0;
      do_after      = 1'b0;
      do_first      = 1'b0;
      do_body       = 1'b0;
      do_string     = 1'b0;
      dig_a         = 4'd0;
      dig_b         = 4'd0;
      dig_bad       = 1'b0;

      // Phase dispatch
      case (phase_ff)
         PH_START: begin
            if (tok.is_quote) begin
               radix_in = RK_STR;
               phase_in = PH_STRING;
            end else if (tok.is_tick) begin
               phase_in = PH_TICK;
            end else begin
               phase_in   = PH_LEAD;
               signed_in  = 1'b1;
               do_lead    = 1'b1;
               lead_first = 1'b1;
            end
         end
         PH_LEAD: do_lead = 1'b1;
         PH_TICK: begin
            if (tok.is_s) begin
               signed_in = 1'b1;
               phase_in  = PH_SIGN;
            end else begin
               do_after = 1'b1;
            end
         end
         PH_SIGN:  do_after = 1'b1;
         PH_FIRST: do_first = 1'b1;
         PH_BODY:  do_body = 1'b1;
         default:  do_string = 1'b1;
      endcase

      // Size or unbased decimal digits before any tick
      if (do_lead) begin
         if (tok.is_dig) begin
            size_in  = (size_x10 > 21'(SIZE_SAT)) ? SIZE_SAT : size_x10[SIZE_W-1:0];
            known_in = known_x10;
         end else if (tok.is_tick) begin
            bad_in        = bad_ff | nondig_ff;
            leadus_in     = 1'b0;
            nondig_in     = 1'b0;
            size_given_in = 1'b1;
            known_in      = '0;
            signed_in     = 1'b0;
            phase_in      = PH_TICK;
         end else if (tok.is_us) begin
            nondig_in = 1'b1;
            if (lead_first) begin
               leadus_in = 1'b1;
            end
         end else begin
            nondig_in = 1'b1;
            bad_in    = 1'b1;
         end
      end

      // Base letter, or a decimal body that starts right here
      if (do_after) begin
         if (tok.base_hit) begin
            radix_in = tok.base_rk;
            phase_in = PH_FIRST;
         end else begin
            radix_in  = RK_DEC;
            signed_in = 1'b1;
            do_first  = 1'b1;
         end
      end

      // First body character
      if (do_first) begin
         if (tok.is_us) begin
            leadus_in = 1'b1;
         end
         phase_in = PH_BODY;
         do_body  = 1'b1;
      end

      // Body digit
      if (do_body && !tok.is_us) begin
         if (radix_in == RK_DEC) begin
            if (tok.is_dig) begin
               known_in = known_x10;
            end else begin
               bad_in = 1'b1;
            end
         end else begin
            if (tok.is_x) begin
               dig_a = 4'hF;
               dig_b = 4'hF;
            end else if (tok.is_z) begin
               dig_b = 4'hF;
            end else begin
               case (radix_in)
                  RK_BIN:  dig_bad = !(tok.is_dig && (tok.dval <= 4'd1));
                  RK_OCT:  dig_bad = !(tok.is_dig && (tok.dval <= 4'd7));
                  default: dig_bad = !tok.is_hex;
               endcase
               dig_a = dig_bad ? 4'd0 : tok.dval;
            end
            case (radix_in)
               RK_BIN: begin
                  known_in   = (known_ff << 1) | MAX_WIDTH'(dig_a[0]);
                  unknown_in = (unknown_ff << 1) | MAX_WIDTH'(dig_b[0]);
               end
               RK_OCT: begin
                  known_in   = (known_ff << 3) | MAX_WIDTH'(dig_a[2:0]);
                  unknown_in = (unknown_ff << 3) | MAX_WIDTH'(dig_b[2:0]);
               end
               default: begin
                  known_in   = (known_ff << 4) | MAX_WIDTH'(dig_a);
                  unknown_in = (unknown_ff << 4) | MAX_WIDTH'(dig_b);
               end
            endcase
            count_in = count_inc;
            if (dig_bad) begin
               inv_seen_in = 1'b1;
               last_inv_in = count_inc - 1'b1;
            end
         end
      end

      // String byte: the newest byte is held back as a possible closing quote
      if (do_string) begin
         if (held_valid_ff) begin
            known_in = (known_ff << 8) | MAX_WIDTH'(held_ff);
            count_in = count_inc;
         end
         held_in       = tok.chr;
         held_valid_in = 1'b1;
      end
   end

   // Snapshot of the state after the final character
   always_comb begin
      snap.radix       = radix_in;
      snap.held_valid  = held_valid_in;
      snap.held_quote  = (held_in == CH_QUOTE);
      snap.count       = count_in;
      snap.size        = size_in;
      snap.size_given  = size_given_in;
      snap.open_phase  = (phase_in == PH_TICK) || (phase_in == PH_SIGN) ||
                         (phase_in == PH_FIRST);
      snap.signed_flag = signed_in;
      snap.bad         = bad_in;
      snap.leadus      = leadus_in;
      snap.inv_seen    = inv_seen_in;
      snap.last_inv    = last_inv_in;
      snap_known       = known_in;
      snap_unknown     = unknown_in;
   end

   // State registers; a finished literal returns the parser to its start
   always_ff @(posedge clock) begin
      if (reset || (tok_pop && tok.last)) begin
         phase_ff      <= PH_START;
         radix_ff      <= RK_DEC;
         signed_ff     <= 1'b0;
         size_ff       <= '0;
         known_ff      <= '0;
         unknown_ff    <= '0;
         count_ff      <= '0;
         last_inv_ff   <= '0;
         inv_seen_ff   <= 1'b0;
         bad_ff        <= 1'b0;
         leadus_ff     <= 1'b0;
         nondig_ff     <= 1'b0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         size_given_ff <= 1'b0;
      end else if (tok_pop) begin
         phase_ff      <= phase_in;
         radix_ff      <= radix_in;
         signed_ff     <= signed_in;
         size_ff       <= size_in;
         known_ff      <= known_in;
         unknown_ff    <= unknown_in;
         count_ff      <= count_in;
         last_inv_ff   <= last_inv_in;
         inv_seen_ff   <= inv_seen_in;
         bad_ff        <= bad_in;
         leadus_ff     <= leadus_in;
         nondig_ff     <= nondig_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         size_given_ff <= size_given_in;
      end
   end

endmodule

### rtl/core/hnlp_finish.sv
// Result stage of the literal parser: registers the end-of-literal
// snapshot, works out width, masks and flags, and holds the result item.
// Uses hnlp_pkg.
module hnlp_finish
   import hnlp_pkg::*;
#(
   parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
   parameter int UNSIZED_WIDTH = UNSIZED_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 snap_valid,
   output logic                 snap_ready,
   input  hnlp_snap_type        snap,
   input  logic [MAX_WIDTH-1:0] snap_known,
   input  logic [MAX_WIDTH-1:0] snap_unknown,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output hnlp_rsp_type         rsp_data
);

   hnlp_snap_type        s_ff;
   logic [MAX_WIDTH-1:0] known_ff, unknown_ff;
   logic                 s_valid_ff, s_valid_in;
   hnlp_rsp_type         rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 load, snap_take;

   logic [18:0]          w_raw;
   logic                 over;
   logic [WIDTH_W-1:0]   w;
   logic                 based;
   logic [COUNT_W-1:0]   cm1, gap;
   logic [17:0]          span;
   logic [WIDTH_W-1:0]   lim;
   logic                 late_bad;
   logic [MAX_WIDTH-1:0] mask;

   // Handshakes around the two registers
   assign load       = s_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign snap_ready = !s_valid_ff || load;
   assign snap_take  = snap_valid && snap_ready;

   always_comb begin
      s_valid_in   = snap_take || (s_valid_ff && !load);
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   // Width, clamp and mask
   always_comb begin
      if (s_ff.radix == RK_STR) begin
         w_raw = {s_ff.count, 3'b000};
      end else if (s_ff.size_given) begin
         w_raw = 19'(s_ff.size);
      end else begin
         w_raw = 19'(UNSIZED_WIDTH);
      end
      over = (w_raw > 19'(MAX_WIDTH));
      w    = over ? WIDTH_W'(MAX_WIDTH) : w_raw[WIDTH_W-1:0];
      mask = ~({MAX_WIDTH{1'b1}} << w);
   end

   // Digits beyond the width: excess count and late invalid digits
   always_comb begin
      based = (s_ff.radix == RK_BIN) || (s_ff.radix == RK_OCT) ||
              (s_ff.radix == RK_HEX);
      cm1   = s_ff.count - 1'b1;
      gap   = cm1 - s_ff.last_inv;
      case (s_ff.radix)
         RK_BIN: begin
            span = 18'(cm1);
            lim  = w;
         end
         RK_OCT: begin
            span = 18'(cm1) + (18'(cm1) << 1);
            lim  = div3(8'(w) + 8'd2);
         end
         default: begin
            span = 18'(cm1) << 2;
            lim  = WIDTH_W'((8'(w) + 8'd3) >> 2);
         end
      endcase
      late_bad = based && (s_ff.count != '0) && s_ff.inv_seen &&
                 (gap <= COUNT_W'(lim));
   end

   // Result item
   always_comb begin
      rsp_in.value_bits         = VALUE_W'(known_ff & mask);
      rsp_in.unknown_bits       = based ? VALUE_W'(unknown_ff & mask) : '0;
      rsp_in.width              = w;
      rsp_in.is_signed          = s_ff.signed_flag;
      rsp_in.bad_character      = s_ff.bad || s_ff.open_phase || late_bad ||
                                  ((s_ff.radix == RK_STR) &&
                                   !(s_ff.held_valid && s_ff.held_quote));
      rsp_in.leading_underscore = s_ff.leadus;
      rsp_in.excess_digits      = based && (s_ff.count != '0) && (span >= 18'(w));
      rsp_in.width_too_large    = over && ((s_ff.radix == RK_STR) || s_ff.size_given);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s_valid_ff   <= s_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_take) begin
         s_ff       <= snap;
         known_ff   <= snap_known;
         unknown_ff <= snap_unknown;
      end
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/core/hdl_number_literal_parser.sv
// HDL number literal parser, top level: front, back and result stage.
// Takes one character per cycle, back to back, while the queue has room; the
// snapshot is registered, then the result item waits in an output register.
// A stalled output stops the back only at a final character, then the queue fills.
// Synchronous active-high reset empties the queue and all stages and returns
// the parser to the start of a literal.
module hdl_number_literal_parser
   import hnlp_pkg::*;
#(
   parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
   parameter int UNSIZED_WIDTH = UNSIZED_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  hnlp_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output hnlp_rsp_type rsp_data
);

   hnlp_token_type       tok;
   logic                 tok_valid, tok_pop;
   hnlp_snap_type        snap;
   logic                 snap_valid, snap_ready;
   logic [MAX_WIDTH-1:0] snap_known, snap_unknown;

   // Classify and queue characters
   hnlp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .tok_valid (tok_valid),
      .tok_pop   (tok_pop),
      .tok       (tok)
   );

   // Parse at most one character per cycle
   hnlp_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .tok_valid    (tok_valid),
      .tok          (tok),
      .tok_pop      (tok_pop),
      .snap_valid   (snap_valid),
      .snap_ready   (snap_ready),
      .snap         (snap),
      .snap_known   (snap_known),
      .snap_unknown (snap_unknown)
   );

   // Build and hold the result item
   hnlp_finish #(
      .MAX_WIDTH     (MAX_WIDTH),
      .UNSIZED_WIDTH (UNSIZED_WIDTH)
   ) u_finish (
      .clock        (clock),
      .reset        (reset),
      .snap_valid   (snap_valid),
      .snap_ready   (snap_ready),
      .snap         (snap),
      .snap_known   (snap_known),
      .snap_unknown (snap_unknown),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule

### rtl/core/hnlp_checker.sv
// Port-level checks for the HDL number literal parser, bound to the top.
// Uses hnlp_pkg for the item types.
module hnlp_checker
   import hnlp_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input hnlp_req_type req_data,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input hnlp_rsp_type rsp_data
);

   // Nothing is pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item shown right after reset");

   // A stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed");

   // Width never exceeds the value ports
   a_width_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.width <= WIDTH_W'(VALUE_W)))
      else $error("result width out of range");

   // Both planes are masked to the width
   a_planes_masked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (((rsp_data.value_bits >> rsp_data.width) == '0) &&
                     ((rsp_data.unknown_bits >> rsp_data.width) == '0)))
      else $error("value bits set beyond the width");

endmodule

bind hdl_number_literal_parser hnlp_checker u_hnlp_checker (.*);
